// ===== rtl/mxv_pkg.sv =====
// Shared types, constants and helper functions for the mirror/XOR video effect.
// This package has no dependencies. All other files reference it by scoped names.
`timescale 1ns / 1ps

package mxv_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_BITS   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int ADDR_BITS  = 1 + ROW_BITS + COL_BITS;
   localparam int STORE_DEPTH = 2 ** ADDR_BITS;

   localparam int PIXEL_BITS = 32;
   localparam int COLOR_BITS = 24;
   localparam int MODE_BITS  = 4;
   localparam int SIZE_BITS  = 7;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [MODE_BITS-1:0]  MODE_RESET   = 4'd0;
   localparam logic [COLOR_BITS-1:0] COLOR_RESET  = 24'd0;
   localparam logic [SIZE_BITS-1:0]  WIDTH_RESET  = 7'd64;
   localparam logic [SIZE_BITS-1:0]  HEIGHT_RESET = 7'd64;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIRROR_MODE  = 2'd0,
      CSR_XOR_COLOR    = 2'd1,
      CSR_FRAME_WIDTH  = 2'd2,
      CSR_FRAME_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_NONE        = 4'd0,
      MODE_LEFT        = 4'd1,
      MODE_RIGHT       = 4'd2,
      MODE_LOWER       = 4'd3,
      MODE_LOWER_LEFT  = 4'd4,
      MODE_LOWER_RIGHT = 4'd5,
      MODE_UPPER       = 4'd6,
      MODE_UPPER_LEFT  = 4'd7,
      MODE_UPPER_RIGHT = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      KEEP_NONE = 2'd0,
      KEEP_LOW  = 2'd1,
      KEEP_HIGH = 2'd2
   } keep_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] fold_mode;
      logic [SIZE_BITS-1:0] frame_width;
      logic [SIZE_BITS-1:0] frame_height;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] wr_addr;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 last;
   } addr_type;

   function automatic keep_type col_keep(input logic [MODE_BITS-1:0] mode);
      keep_type k;
      unique case (mode)
         MODE_LEFT, MODE_LOWER_LEFT, MODE_UPPER_LEFT:    k = KEEP_LOW;
         MODE_RIGHT, MODE_LOWER_RIGHT, MODE_UPPER_RIGHT: k = KEEP_HIGH;
         default:                                        k = KEEP_NONE;
      endcase
      return k;
   endfunction

   function automatic keep_type row_keep(input logic [MODE_BITS-1:0] mode);
      keep_type k;
      unique case (mode)
         MODE_UPPER, MODE_UPPER_LEFT, MODE_UPPER_RIGHT:  k = KEEP_LOW;
         MODE_LOWER, MODE_LOWER_LEFT, MODE_LOWER_RIGHT:  k = KEEP_HIGH;
         default:                                        k = KEEP_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [COL_BITS:0] clamp_width(input logic [SIZE_BITS-1:0] v);
      logic [COL_BITS:0] s;
      if (v == '0) begin
         s = (COL_BITS+1)'(1);
      end else if (32'(v) > 32'(MAX_WIDTH)) begin
         s = (COL_BITS+1)'(MAX_WIDTH);
      end else begin
         s = (COL_BITS+1)'(v);
      end
      return s;
   endfunction

   function automatic logic [ROW_BITS:0] clamp_height(input logic [SIZE_BITS-1:0] v);
      logic [ROW_BITS:0] s;
      if (v == '0) begin
         s = (ROW_BITS+1)'(1);
      end else if (32'(v) > 32'(MAX_HEIGHT)) begin
         s = (ROW_BITS+1)'(MAX_HEIGHT);
      end else begin
         s = (ROW_BITS+1)'(v);
      end
      return s;
   endfunction

   function automatic logic [COL_BITS-1:0] fold_col(input logic [COL_BITS-1:0] c,
                                                   input logic [COL_BITS:0]   size,
                                                   input keep_type            keep);
      logic [COL_BITS:0]   ce;
      logic [COL_BITS:0]   me;
      logic [COL_BITS-1:0] m;
      logic [COL_BITS-1:0] r;
      ce = {1'b0, c};
      me = size - (COL_BITS+1)'(1) - ce;
      m  = me[COL_BITS-1:0];
      if (keep == KEEP_NONE || ce >= size) begin
         r = c;
      end else if (keep == KEEP_LOW) begin
         r = (c < m) ? c : m;
      end else begin
         r = (c > m) ? c : m;
      end
      return r;
   endfunction

   function automatic logic [ROW_BITS-1:0] fold_row(input logic [ROW_BITS-1:0] c,
                                                   input logic [ROW_BITS:0]   size,
                                                   input keep_type            keep);
      logic [ROW_BITS:0]   ce;
      logic [ROW_BITS:0]   me;
      logic [ROW_BITS-1:0] m;
      logic [ROW_BITS-1:0] r;
      ce = {1'b0, c};
      me = size - (ROW_BITS+1)'(1) - ce;
      m  = me[ROW_BITS-1:0];
      if (keep == KEEP_NONE || ce >= size) begin
         r = c;
      end else if (keep == KEEP_LOW) begin
         r = (c < m) ? c : m;
      end else begin
         r = (c > m) ? c : m;
      end
      return r;
   endfunction

endpackage

// ===== rtl/mxv_addr_gen.sv =====
// Raster position counters, bank select and mirrored read address generation.
// Depends on mxv_pkg for widths, the configuration struct and the fold functions.
`timescale 1ns / 1ps

module mxv_addr_gen (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  mxv_pkg::cfg_type  cfg,
   output mxv_pkg::addr_type addr
);

   logic [mxv_pkg::COL_BITS-1:0] col_ff, col_in;
   logic [mxv_pkg::ROW_BITS-1:0] row_ff, row_in;
   logic                         bank_ff, bank_in;

   logic [mxv_pkg::COL_BITS:0]   w;
   logic [mxv_pkg::ROW_BITS:0]   h;
   logic [mxv_pkg::COL_BITS-1:0] src_col;
   logic [mxv_pkg::ROW_BITS-1:0] src_row;
   logic                         line_end;
   logic                         frame_last;

   always_comb begin
      w = mxv_pkg::clamp_width(cfg.frame_width);
      h = mxv_pkg::clamp_height(cfg.frame_height);
      src_col = mxv_pkg::fold_col(col_ff, w, mxv_pkg::col_keep(cfg.fold_mode));
      src_row = mxv_pkg::fold_row(row_ff, h, mxv_pkg::row_keep(cfg.fold_mode));
      line_end   = ({1'b0, col_ff} + (mxv_pkg::COL_BITS+1)'(1)) >= w;
      frame_last = line_end && (({1'b0, row_ff} + (mxv_pkg::ROW_BITS+1)'(1)) >= h);
   end

   assign addr.wr_addr = {bank_ff, row_ff, col_ff};
   assign addr.rd_addr = {~bank_ff, src_row, src_col};
   assign addr.last    = frame_last;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      bank_in = bank_ff;
      if (advance) begin
         if (line_end) begin
            col_in = '0;
            if (frame_last) begin
               row_in  = '0;
               bank_in = ~bank_ff;
            end else begin
               row_in = row_ff + mxv_pkg::ROW_BITS'(1);
            end
         end else begin
            col_in = col_ff + mxv_pkg::COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         bank_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         bank_ff <= bank_in;
      end
   end

endmodule

// ===== rtl/mxv_frame_store.sv =====
// Two-bank frame store: one write port, one registered read port, and a
// clearing sweep after reset that zeroes every word. Depends on mxv_pkg.
`timescale 1ns / 1ps

module mxv_frame_store (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [mxv_pkg::ADDR_BITS-1:0]  wr_addr,
   input  logic [mxv_pkg::PIXEL_BITS-1:0] wr_data,
   input  logic                           rd_en,
   input  logic [mxv_pkg::ADDR_BITS-1:0]  rd_addr,
   output logic [mxv_pkg::PIXEL_BITS-1:0] rd_data,
   output logic                           busy
);

   logic [mxv_pkg::PIXEL_BITS-1:0] mem [mxv_pkg::STORE_DEPTH];
   logic [mxv_pkg::PIXEL_BITS-1:0] rd_data_ff;
   logic                           clr_ff, clr_in;
   logic [mxv_pkg::ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + mxv_pkg::ADDR_BITS'(1);
         if (clr_addr_ff == mxv_pkg::ADDR_BITS'(mxv_pkg::STORE_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_ff;

endmodule

// ===== rtl/mirror_xor_video_effect_top.sv =====
// Top level of the mirror/XOR video effect: configuration registers, handshake
// control and output register. Depends on mxv_pkg, mxv_addr_gen, mxv_frame_store.
//
// Usage: pixels enter in raster order on the req_ channel, one word per
// accepted handshake. Each accepted word produces exactly one word on the rsp_
// channel: the previous frame's pixel at the mirrored position, XORed with
// xor_color in its low 24 bits, with rsp_frame_end marking the last position.
// Configuration is written through csr_write, csr_index and csr_wdata while
// the block is idle.
// A word accepted on req_ passes the registered frame store read and then the
// output register before it is presented on rsp_. Throughput is one word per
// cycle while req_ready is high, set by the single-port write and single-port
// registered read of the frame store, one of each per cycle.
// After reset the frame store is swept to zero, one word per cycle over all 8192
// words, and req_ready stays low until the sweep ends; configuration writes are
// accepted throughout. When the receiver stalls, the output register and the
// read stage hold their words and req_ready drops once both are full.
`timescale 1ns / 1ps

module mirror_xor_video_effect_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mxv_pkg::PIXEL_BITS-1:0]      req_in_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mxv_pkg::PIXEL_BITS-1:0]      rsp_out_pixel,
   output logic                                rsp_frame_end,
   input  logic                                csr_write,
   input  logic [mxv_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mxv_pkg::COLOR_BITS-1:0]      csr_wdata
);

   logic [mxv_pkg::MODE_BITS-1:0]  mode_ff;
   logic [mxv_pkg::COLOR_BITS-1:0] color_ff;
   logic [mxv_pkg::SIZE_BITS-1:0]  width_ff;
   logic [mxv_pkg::SIZE_BITS-1:0]  height_ff;

   mxv_pkg::cfg_type  cfg;
   mxv_pkg::addr_type addr;

   logic                           busy;
   logic [mxv_pkg::PIXEL_BITS-1:0] rd_data;
   logic                           accept;
   logic                           out_free;
   logic                           s1_move;

   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_last_ff, s1_last_in;
   logic                           out_valid_ff, out_valid_in;
   logic [mxv_pkg::PIXEL_BITS-1:0] out_pixel_ff, out_pixel_in;
   logic                           out_last_ff, out_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= mxv_pkg::MODE_RESET;
         color_ff  <= mxv_pkg::COLOR_RESET;
         width_ff  <= mxv_pkg::WIDTH_RESET;
         height_ff <= mxv_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (mxv_pkg::csr_index_type'(csr_index))
            mxv_pkg::CSR_MIRROR_MODE:  mode_ff   <= csr_wdata[mxv_pkg::MODE_BITS-1:0];
            mxv_pkg::CSR_XOR_COLOR:    color_ff  <= csr_wdata;
            mxv_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[mxv_pkg::SIZE_BITS-1:0];
            mxv_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata[mxv_pkg::SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.fold_mode    = mode_ff;
   assign cfg.frame_width  = width_ff;
   assign cfg.frame_height = height_ff;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !busy && (!s1_valid_ff || out_free);
   assign accept    = req_valid && req_ready;

   mxv_addr_gen u_addr_gen (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .cfg     (cfg),
      .addr    (addr)
   );

   mxv_frame_store u_frame_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_addr (addr.wr_addr),
      .wr_data (req_in_pixel),
      .rd_en   (accept),
      .rd_addr (addr.rd_addr),
      .rd_data (rd_data),
      .busy    (busy)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_last_in   = s1_last_ff;
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_last_in  = out_last_ff;
      if (s1_move) begin
         s1_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_pixel_in = rd_data ^ {{(mxv_pkg::PIXEL_BITS-mxv_pkg::COLOR_BITS){1'b0}}, color_ff};
         out_last_in  = s1_last_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_last_in  = addr.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff   <= s1_last_in;
      out_pixel_ff <= out_pixel_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_pixel = out_pixel_ff;
   assign rsp_frame_end = out_last_ff;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready)
      else $error("input accepted while the frame store is being cleared");

   a_full_pipe_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted with both stages full and the receiver stalled");

   a_read_stage_feeds_output: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |=> out_valid_ff)
      else $error("word in the read stage was not moved to the output register");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for mirror_xor_video_effect_top: directed frames, then random phases.
// Predicts each output word with its own model of the two-bank store; needs mxv_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned BANK_WORDS    = mxv_pkg::MAX_WIDTH * mxv_pkg::MAX_HEIGHT;
   localparam int unsigned RANDOM_ITEMS  = 1800;
   localparam int unsigned SETTLE_CYCLES = 3;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned BACKLOG_HOLD  = 300;
   localparam int unsigned DIRECTED_ROWS = 39;
   localparam logic [mxv_pkg::MODE_BITS-1:0] MODE_UNDEFINED = 4'd15;

   typedef struct packed {
      logic [mxv_pkg::PIXEL_BITS-1:0] pixel;
      logic                           frame_end;
   } video_word_type;

   typedef struct packed {
      logic                           is_write;
      mxv_pkg::csr_index_type         idx;
      logic [mxv_pkg::COLOR_BITS-1:0] data;
      logic [mxv_pkg::PIXEL_BITS-1:0] pixel;
      logic                           typed;
      logic [mxv_pkg::PIXEL_BITS-1:0] exp_pixel;
      logic                           exp_end;
   } stim_row_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [mxv_pkg::PIXEL_BITS-1:0]     req_in_pixel;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [mxv_pkg::PIXEL_BITS-1:0]     rsp_out_pixel;
   logic                               rsp_frame_end;
   logic                               csr_write;
   logic [mxv_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [mxv_pkg::COLOR_BITS-1:0]     csr_wdata;

   logic [mxv_pkg::PIXEL_BITS-1:0] mirror_frames [0:2*BANK_WORDS-1];
   logic                           write_bank;
   int unsigned                    raster_col;
   int unsigned                    raster_row;
   logic [mxv_pkg::MODE_BITS-1:0]  mode_reg;
   logic [mxv_pkg::COLOR_BITS-1:0] color_reg;
   logic [mxv_pkg::SIZE_BITS-1:0]  width_reg;
   logic [mxv_pkg::SIZE_BITS-1:0]  height_reg;

   video_word_type pending_words [$];
   int unsigned words_sent;
   int unsigned failures = 0;
   logic        quiet_phase;
   logic        backlog_request;
   logic        backlog_done = 1'b0;

   stim_row_type directed_table [0:DIRECTED_ROWS-1] = '{
      '{1'b1, mxv_pkg::CSR_XOR_COLOR,    24'hABCDEF, 32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_FRAME_WIDTH,  24'd2,      32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_FRAME_HEIGHT, 24'd2,      32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_MIRROR_MODE,  24'(mxv_pkg::MODE_NONE), 32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h00000000, 1'b1, 32'h00ABCDEF, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'hFFFFFFFF, 1'b1, 32'h00ABCDEF, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h12345678, 1'b1, 32'h00ABCDEF, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h80000001, 1'b1, 32'h00ABCDEF, 1'b1},
      '{1'b1, mxv_pkg::CSR_MIRROR_MODE,  24'(mxv_pkg::MODE_LEFT), 32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_XOR_COLOR,    24'h000000, 32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'hA5A5A5A5, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h5A5A5A5A, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h00000001, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_MIRROR_MODE,  24'(mxv_pkg::MODE_UPPER_RIGHT),
        32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_FRAME_WIDTH,  24'd3,      32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_FRAME_HEIGHT, 24'd3,      32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_XOR_COLOR,    24'hFFFFFF, 32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h11111111, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h22222222, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h33333333, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h44444444, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h55555555, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h66666666, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h77777777, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h88888888, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h99999999, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_FRAME_WIDTH,  24'd5,      32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'hDEADBEEF, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'hCAFEF00D, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h0F0F0F0F, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_FRAME_WIDTH,  24'd2,      32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'hF0F0F0F0, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_MIRROR_MODE,  24'(MODE_UNDEFINED), 32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_FRAME_WIDTH,  24'd0,      32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b1, mxv_pkg::CSR_FRAME_HEIGHT, 24'd127,    32'h0, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h80000000, 1'b0, 32'h0, 1'b0},
      '{1'b0, mxv_pkg::CSR_MIRROR_MODE,  24'h0, 32'h00000001, 1'b0, 32'h0, 1'b0}
   };

   mirror_xor_video_effect_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_pixel  (req_in_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_frame_end (rsp_frame_end),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned fit_size(input logic [mxv_pkg::SIZE_BITS-1:0] v,
                                            input int unsigned limit);
      if (v == '0) begin
         return 1;
      end
      return (int'(v) > limit) ? limit : int'(v);
   endfunction

   function automatic int unsigned reflect(input int unsigned c, input int unsigned size,
                                           input mxv_pkg::keep_type rule);
      int unsigned opposite;
      if (rule == mxv_pkg::KEEP_NONE || c >= size) begin
         return c;
      end
      opposite = size - 1 - c;
      if (rule == mxv_pkg::KEEP_LOW) begin
         return (c < opposite) ? c : opposite;
      end
      return (c > opposite) ? c : opposite;
   endfunction

   function automatic video_word_type predict_mirror(
      input logic [mxv_pkg::PIXEL_BITS-1:0] in_pixel);
      int unsigned       w;
      int unsigned       h;
      int unsigned       col;
      int unsigned       row;
      int unsigned       src_col;
      int unsigned       src_row;
      int unsigned       rd_base;
      int unsigned       wr_base;
      mxv_pkg::keep_type col_rule;
      mxv_pkg::keep_type row_rule;
      video_word_type    word;
      w   = fit_size(width_reg, mxv_pkg::MAX_WIDTH);
      h   = fit_size(height_reg, mxv_pkg::MAX_HEIGHT);
      col = (raster_col >= mxv_pkg::MAX_WIDTH) ? mxv_pkg::MAX_WIDTH - 1 : raster_col;
      row = (raster_row >= mxv_pkg::MAX_HEIGHT) ? mxv_pkg::MAX_HEIGHT - 1 : raster_row;
      case (mode_reg)
         mxv_pkg::MODE_LEFT, mxv_pkg::MODE_LOWER_LEFT, mxv_pkg::MODE_UPPER_LEFT:
            col_rule = mxv_pkg::KEEP_LOW;
         mxv_pkg::MODE_RIGHT, mxv_pkg::MODE_LOWER_RIGHT, mxv_pkg::MODE_UPPER_RIGHT:
            col_rule = mxv_pkg::KEEP_HIGH;
         default:
            col_rule = mxv_pkg::KEEP_NONE;
      endcase
      case (mode_reg)
         mxv_pkg::MODE_UPPER, mxv_pkg::MODE_UPPER_LEFT, mxv_pkg::MODE_UPPER_RIGHT:
            row_rule = mxv_pkg::KEEP_LOW;
         mxv_pkg::MODE_LOWER, mxv_pkg::MODE_LOWER_LEFT, mxv_pkg::MODE_LOWER_RIGHT:
            row_rule = mxv_pkg::KEEP_HIGH;
         default:
            row_rule = mxv_pkg::KEEP_NONE;
      endcase
      src_col = reflect(col, w, col_rule);
      src_row = reflect(row, h, row_rule);
      wr_base = write_bank ? BANK_WORDS : 0;
      rd_base = write_bank ? 0 : BANK_WORDS;
      word.pixel = mirror_frames[rd_base + src_row * mxv_pkg::MAX_WIDTH + src_col]
                   ^ {8'h00, color_reg};
      word.frame_end = 1'b0;
      mirror_frames[wr_base + row * mxv_pkg::MAX_WIDTH + col] = in_pixel;
      if (col + 1 >= w) begin
         raster_col = 0;
         if (row + 1 >= h) begin
            raster_row = 0;
            write_bank = ~write_bank;
            word.frame_end = 1'b1;
         end else begin
            raster_row = row + 1;
         end
      end else begin
         raster_col = col + 1;
         raster_row = row;
      end
      return word;
   endfunction

   function automatic logic [mxv_pkg::COLOR_BITS-1:0] with_junk(
      input logic [mxv_pkg::COLOR_BITS-1:0] v, input int unsigned used);
      logic [mxv_pkg::COLOR_BITS-1:0] junk;
      junk = mxv_pkg::COLOR_BITS'($urandom) << used;
      return ($urandom_range(3) == 0) ? (v | junk) : v;
   endfunction

   function automatic logic [mxv_pkg::SIZE_BITS-1:0] pick_size();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) begin
         return mxv_pkg::SIZE_BITS'($urandom_range(1, 8));
      end else if (r < 80) begin
         return mxv_pkg::SIZE_BITS'($urandom_range(9, 20));
      end else if (r < 86) begin
         return '0;
      end else if (r < 93) begin
         return mxv_pkg::SIZE_BITS'(mxv_pkg::MAX_WIDTH);
      end
      return mxv_pkg::SIZE_BITS'($urandom_range(65, 127));
   endfunction

   task automatic write_register(input mxv_pkg::csr_index_type idx,
                                 input logic [mxv_pkg::COLOR_BITS-1:0] data);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         mxv_pkg::CSR_MIRROR_MODE:  mode_reg   = data[mxv_pkg::MODE_BITS-1:0];
         mxv_pkg::CSR_XOR_COLOR:    color_reg  = data;
         mxv_pkg::CSR_FRAME_WIDTH:  width_reg  = data[mxv_pkg::SIZE_BITS-1:0];
         mxv_pkg::CSR_FRAME_HEIGHT: height_reg = data[mxv_pkg::SIZE_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic offer_pixel(input logic [mxv_pkg::PIXEL_BITS-1:0] pixel,
                              output video_word_type predicted);
      while (!quiet_phase && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_pixel <= pixel;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = predict_mirror(pixel);
      words_sent++;
   endtask

   initial begin : response_sink
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (backlog_request && !backlog_done) begin
            hold_left    = BACKLOG_HOLD;
            backlog_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (quiet_phase) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 9);
         end
      end
   end

   always @(posedge clock) begin
      video_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $error("out_pixel expected none actual %h", rsp_out_pixel);
            failures++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_out_pixel !== want.pixel) begin
               $error("out_pixel expected %h actual %h", want.pixel, rsp_out_pixel);
               failures++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end expected %b actual %b", want.frame_end, rsp_frame_end);
               failures++;
            end
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("FAIL mirror_xor_video_effect_top");
      $finish;
   end

   initial begin : stimulus
      video_word_type                 word;
      int unsigned                    phase;
      int unsigned                    burst;
      int unsigned                    area;
      int unsigned                    remaining;
      logic [mxv_pkg::SIZE_BITS-1:0]  new_w;
      logic [mxv_pkg::SIZE_BITS-1:0]  new_h;
      logic [mxv_pkg::MODE_BITS-1:0]  new_mode;
      logic [mxv_pkg::COLOR_BITS-1:0] new_color;
      int unsigned                    r;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_in_pixel    <= '0;
      csr_write       <= 1'b0;
      csr_index       <= mxv_pkg::CSR_MIRROR_MODE;
      csr_wdata       <= '0;
      words_sent      = 0;
      quiet_phase     = 1'b0;
      backlog_request = 1'b0;
      foreach (mirror_frames[i]) begin
         mirror_frames[i] = '0;
      end
      write_bank = 1'b0;
      raster_col = 0;
      raster_row = 0;
      mode_reg   = mxv_pkg::MODE_RESET;
      color_reg  = mxv_pkg::COLOR_RESET;
      width_reg  = mxv_pkg::WIDTH_RESET;
      height_reg = mxv_pkg::HEIGHT_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_table[i]) begin
         if (directed_table[i].is_write) begin
            write_register(directed_table[i].idx, directed_table[i].data);
         end else begin
            offer_pixel(directed_table[i].pixel, word);
            if (directed_table[i].typed) begin
               word.pixel     = directed_table[i].exp_pixel;
               word.frame_end = directed_table[i].exp_end;
            end
            pending_words.push_back(word);
         end
      end

      phase = 0;
      while (words_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if (phase == 0) begin
            // The receiver holds off for a stretch at the start of this phase so the pipeline backs up.
            write_register(mxv_pkg::CSR_FRAME_WIDTH, 24'd16);
            write_register(mxv_pkg::CSR_FRAME_HEIGHT, 24'd16);
            write_register(mxv_pkg::CSR_MIRROR_MODE,
                           24'($urandom_range(mxv_pkg::MODE_UPPER_RIGHT)));
            burst           = 512;
            backlog_request = 1'b1;
         end else begin
            if ($urandom_range(99) < 60) begin
               r = $urandom_range(99);
               new_mode = (r < 85)
                  ? mxv_pkg::MODE_BITS'($urandom_range(mxv_pkg::MODE_UPPER_RIGHT))
                  : mxv_pkg::MODE_BITS'($urandom_range(9, 15));
               write_register(mxv_pkg::CSR_MIRROR_MODE,
                              with_junk(24'(new_mode), mxv_pkg::MODE_BITS));
            end
            if ($urandom_range(99) < 60) begin
               r = $urandom_range(99);
               new_color = (r < 10) ? 24'h000000 : (r < 20) ? 24'hFFFFFF : 24'($urandom);
               write_register(mxv_pkg::CSR_XOR_COLOR, new_color);
            end
            if ($urandom_range(99) < 60) begin
               new_w = pick_size();
               new_h = pick_size();
               if (fit_size(new_w, mxv_pkg::MAX_WIDTH) *
                   fit_size(new_h, mxv_pkg::MAX_HEIGHT) > 256) begin
                  new_h = mxv_pkg::SIZE_BITS'($urandom_range(1, 4));
               end
               write_register(mxv_pkg::CSR_FRAME_WIDTH,
                              with_junk(24'(new_w), mxv_pkg::SIZE_BITS));
               write_register(mxv_pkg::CSR_FRAME_HEIGHT,
                              with_junk(24'(new_h), mxv_pkg::SIZE_BITS));
            end
            area  = fit_size(width_reg, mxv_pkg::MAX_WIDTH) *
                    fit_size(height_reg, mxv_pkg::MAX_HEIGHT);
            burst = area * ((area <= 64) ? $urandom_range(2, 4) : $urandom_range(1, 2));
            burst += $urandom_range(fit_size(width_reg, mxv_pkg::MAX_WIDTH) - 1);
            if (phase == 3) begin
               burst = 300;
            end
         end
         remaining = DIRECTED_ROWS + RANDOM_ITEMS - words_sent;
         if (burst > remaining) begin
            burst = remaining;
         end
         quiet_phase = (phase == 3);
         repeat (burst) begin
            offer_pixel(32'($urandom), word);
            pending_words.push_back(word);
         end
         backlog_request = 1'b0;
         quiet_phase     = 1'b0;
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("PASS mirror_xor_video_effect_top");
      end else begin
         $display("FAIL mirror_xor_video_effect_top");
      end
      $finish;
   end

endmodule
